[sv/bmpc_pkg.sv]
// ============================================================================
// bmpc_pkg
// Types and constants shared by the blind motor position controller modules.
// ============================================================================
package bmpc_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_MAX_TRAVEL   = 3'd0;
    localparam logic [2:0] CFG_HAS_LIMITS   = 3'd1;
    localparam logic [2:0] CFG_TOP_FITTED   = 3'd2;
    localparam logic [2:0] CFG_BOT_FITTED   = 3'd3;
    localparam logic [2:0] CFG_NORMAL_SPEED = 3'd4;
    localparam logic [2:0] CFG_HOMING_RATE  = 3'd5;
    localparam logic [2:0] CFG_ACCEL_RATE   = 3'd6;

    // Motion constants
    localparam logic signed [20:0] HOMING_DISTANCE  = 21'sd1000000;
    localparam logic signed [20:0] RETRACT_DISTANCE = -21'sd100;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x below 2**30
    localparam logic [26:0] RECIP_100   = 27'd85899346;
    localparam int          RECIP_SHIFT = 33;

    // Payload widths
    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_ADDR_W = 3;

    typedef enum logic [2:0] {
        ACT_TICK    = 3'd0,
        ACT_INIT    = 3'd1,
        ACT_UP      = 3'd2,
        ACT_DOWN    = 3'd3,
        ACT_PERCENT = 3'd4,
        ACT_STOP    = 3'd5,
        ACT_HOME    = 3'd6
    } t_action;

    typedef enum logic [2:0] {
        ST_UNKNOWN = 3'd0,
        ST_IDLE    = 3'd1,
        ST_UP      = 3'd2,
        ST_DOWN    = 3'd3,
        ST_HOMING  = 3'd4,
        ST_FAULT   = 3'd5
    } t_blind_state;

    typedef enum logic [1:0] {
        PH_NONE      = 2'd0,
        PH_TO_BOTTOM = 2'd1,
        PH_RETRACT   = 2'd2
    } t_phase;

    typedef enum logic [3:0] {
        CMD_STATUS  = 4'd0,
        CMD_SPEED   = 4'd1,
        CMD_ACCEL   = 4'd2,
        CMD_ENABLE  = 4'd3,
        CMD_SETPOS  = 4'd4,
        CMD_MOVETO  = 4'd5,
        CMD_MOVEREL = 4'd6,
        CMD_STOP    = 4'd7,
        CMD_ESTOP   = 4'd8,
        CMD_SAVE    = 4'd9
    } t_cmd;

    typedef enum logic [1:0] {
        F_IDLE,
        F_PROD,
        F_RECIP,
        F_EXEC
    } t_front_state;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CMD,
        BK_SCALE,
        BK_DIV,
        BK_STATUS
    } t_back_state;

    typedef struct packed {
        logic [19:0] max_travel;
        logic        has_limits;
        logic        top_fitted;
        logic        bot_fitted;
        logic [19:0] normal_speed;
        logic [19:0] homing_rate;
        logic [19:0] accel_rate;
    } t_cfg;

    typedef struct packed {
        t_cmd        code;
        logic [20:0] value;
    } t_cmd_entry;

    // One classified request: its command run and what the status needs
    typedef struct packed {
        t_cmd_entry [3:0] cmds;
        logic [2:0]       count;
        logic [20:0]      pos;
        t_blind_state     state;
    } t_job;

endpackage

[sv/blind_motor_position_controller_top.sv]
// ============================================================================
// blind_motor_position_controller_top
// Stepper blind controller: request stream in, motor command stream out.
// ============================================================================
// Each request (tick, initialize, up, down, to-percent, stop, home) yields zero
// to four motor or storage commands followed by one status item flagged by
// tlast. The front captures and classifies a request (F_IDLE, F_PROD, F_RECIP,
// F_EXEC) and hands it to a two-entry queue, so it can take a new request while
// the back is still busy; the back sends one command per cycle while the result
// side accepts, then runs a seven-step restoring divider for the status percent,
// which it skips when the position lies outside the travel range. The user must
// write configuration through i_cfg_we / i_cfg_addr / i_cfg_wdata only while no
// request is in flight; the block itself does not enforce this.
module blind_motor_position_controller_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [bmpc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [bmpc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // request stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // percent_request[7:0], motor_running[8], motor_position[29:9],
    // top_switch_hit[30], bottom_switch_hit[31], stored_position[52:32]
    input  logic [bmpc_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // action[2:0]
    input  logic [bmpc_pkg::IN_USER_W-1:0]  i_s_axis_tuser,
    // result stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // motor_command[3:0], command_value[24:4], blind_state[27:25],
    // position_percent[34:28]
    output logic [bmpc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // last_of_run
    output logic                            o_m_axis_tlast
);
    import bmpc_pkg::*;

    t_cfg r_cfg;
    logic w_q_full, w_q_push, w_q_pop, w_q_valid;
    t_job w_push_job, w_pop_job;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_travel   <= 20'd10000;
            r_cfg.has_limits   <= 1'b0;
            r_cfg.top_fitted   <= 1'b0;
            r_cfg.bot_fitted   <= 1'b0;
            r_cfg.normal_speed <= 20'd1000;
            r_cfg.homing_rate  <= 20'd500;
            r_cfg.accel_rate   <= 20'd1000;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MAX_TRAVEL:   r_cfg.max_travel   <= i_cfg_wdata;
                CFG_HAS_LIMITS:   r_cfg.has_limits   <= i_cfg_wdata[0];
                CFG_TOP_FITTED:   r_cfg.top_fitted   <= i_cfg_wdata[0];
                CFG_BOT_FITTED:   r_cfg.bot_fitted   <= i_cfg_wdata[0];
                CFG_NORMAL_SPEED: r_cfg.normal_speed <= i_cfg_wdata;
                CFG_HOMING_RATE:  r_cfg.homing_rate  <= i_cfg_wdata;
                CFG_ACCEL_RATE:   r_cfg.accel_rate   <= i_cfg_wdata;
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    bmpc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_user   (i_s_axis_tuser),
        .i_data   (i_s_axis_tdata),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_q_job  (w_push_job)
    );

    bmpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_job   (w_push_job),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_job   (w_pop_job)
    );

    bmpc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max_travel (r_cfg.max_travel),
        .i_q_valid    (w_q_valid),
        .i_q_job      (w_pop_job),
        .o_q_pop      (w_q_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_data       (o_m_axis_tdata),
        .o_last       (o_m_axis_tlast)
    );

endmodule

[sv/bmpc_front.sv]
// ============================================================================
// bmpc_front
// Accepts requests, updates blind state and homing phase, and queues the
// resulting command run together with the position for the status percent.
// ============================================================================
module bmpc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bmpc_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [bmpc_pkg::IN_USER_W-1:0] i_user,
    input  logic [bmpc_pkg::IN_DATA_W-1:0] i_data,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output bmpc_pkg::t_job                o_q_job
);
    import bmpc_pkg::*;

    t_front_state r_state, n_state;
    t_blind_state r_mode, n_mode;
    t_phase       r_phase, n_phase;

    // Captured request fields
    t_action            r_action;
    logic signed [7:0]  r_pct_req;
    logic               r_running;
    logic signed [20:0] r_pos;
    logic               r_top_hit;
    logic               r_bot_hit;
    logic signed [20:0] r_stored;

    logic [26:0] r_prod;
    logic [19:0] r_target;

    logic [6:0]         w_pct_clamped;
    logic [53:0]        w_recip_full;
    logic signed [20:0] w_max_s;
    logic signed [20:0] w_target_s;
    logic               w_top, w_bot, w_busy;
    logic signed [20:0] w_p;
    logic [2:0]         w_idx;
    t_job               w_job;

    assign o_ready = (r_state == F_IDLE);

    // Clamp requested percent to 0..100
    always_comb begin
        if (r_pct_req < 8'sd0) begin
            w_pct_clamped = 7'd0;
        end else if (r_pct_req > 8'sd100) begin
            w_pct_clamped = 7'd100;
        end else begin
            w_pct_clamped = r_pct_req[6:0];
        end
    end

    assign w_recip_full = r_prod * RECIP_100;
    assign w_max_s      = $signed({1'b0, i_cfg.max_travel});
    assign w_target_s   = $signed({1'b0, r_target});
    assign w_top        = i_cfg.top_fitted & r_top_hit;
    assign w_bot        = i_cfg.bot_fitted & r_bot_hit;
    assign w_busy       = (r_mode == ST_HOMING) || (r_mode == ST_FAULT);

    // Next state of the front sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (i_valid) n_state = F_PROD;
            F_PROD:  n_state = F_RECIP;
            F_RECIP: n_state = F_EXEC;
            F_EXEC:  if (!i_q_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // Classify the request and build its command run
    always_comb begin
        n_mode      = r_mode;
        n_phase     = r_phase;
        w_p         = r_pos;
        w_idx       = 3'd0;
        w_job       = '0;
        w_job.cmds  = '0;
        case (r_action)
            ACT_TICK: begin
                if (r_phase == PH_NONE) begin
                    if (w_top && n_mode == ST_UP) begin
                        w_job.cmds[w_idx[1:0]] = '{CMD_ESTOP, 21'd0};
                        w_idx = w_idx + 3'd1;
                        w_job.cmds[w_idx[1:0]] = '{CMD_SETPOS, 21'd0};
                        w_idx = w_idx + 3'd1;
                        w_p    = 21'sd0;
                        n_mode = ST_IDLE;
                    end
                    if (w_bot && n_mode == ST_DOWN) begin
                        w_job.cmds[w_idx[1:0]] = '{CMD_ESTOP, 21'd0};
                        w_idx = w_idx + 3'd1;
                        w_job.cmds[w_idx[1:0]] = '{CMD_SETPOS, w_max_s};
                        w_idx = w_idx + 3'd1;
                        w_p    = w_max_s;
                        n_mode = ST_IDLE;
                    end
                end
                if (n_mode == ST_HOMING) begin
                    if (r_phase == PH_TO_BOTTOM) begin
                        if (w_bot) begin
                            w_job.cmds[w_idx[1:0]] = '{CMD_STOP, 21'd0};
                            w_idx = w_idx + 3'd1;
                            w_job.cmds[w_idx[1:0]] = '{CMD_SETPOS, w_max_s};
                            w_idx = w_idx + 3'd1;
                            w_job.cmds[w_idx[1:0]] = '{CMD_MOVEREL, RETRACT_DISTANCE};
                            w_idx = w_idx + 3'd1;
                            w_p     = w_max_s;
                            n_phase = PH_RETRACT;
                        end
                    end else if (r_phase == PH_RETRACT) begin
                        if (!r_running) begin
                            w_job.cmds[w_idx[1:0]] = '{CMD_SAVE, w_max_s};
                            w_idx = w_idx + 3'd1;
                            n_phase = PH_NONE;
                            n_mode  = ST_IDLE;
                        end
                    end
                end else if (!r_running && (n_mode == ST_UP || n_mode == ST_DOWN)) begin
                    w_job.cmds[w_idx[1:0]] = '{CMD_SAVE, w_p};
                    w_idx = w_idx + 3'd1;
                    n_mode = ST_IDLE;
                end
            end
            ACT_INIT: begin
                w_job.cmds[0] = '{CMD_SPEED, {1'b0, i_cfg.normal_speed}};
                w_job.cmds[1] = '{CMD_ACCEL, {1'b0, i_cfg.accel_rate}};
                w_job.cmds[2] = '{CMD_ENABLE, 21'd1};
                w_idx = 3'd3;
                if (!r_stored[20] && (r_stored <= w_max_s)) begin
                    w_job.cmds[3] = '{CMD_SETPOS, r_stored};
                    w_idx  = 3'd4;
                    w_p    = r_stored;
                    n_mode = ST_IDLE;
                end else begin
                    n_mode = ST_UNKNOWN;
                end
            end
            ACT_UP: begin
                if (!w_busy && !(r_pos <= 21'sd0 && !i_cfg.has_limits)) begin
                    w_job.cmds[0] = '{CMD_MOVETO, 21'd0};
                    w_idx  = 3'd1;
                    n_mode = ST_UP;
                end
            end
            ACT_DOWN: begin
                if (!w_busy && !(r_pos >= w_max_s && !i_cfg.has_limits)) begin
                    w_job.cmds[0] = '{CMD_MOVETO, w_max_s};
                    w_idx  = 3'd1;
                    n_mode = ST_DOWN;
                end
            end
            ACT_PERCENT: begin
                if (!w_busy && (w_target_s != r_pos)) begin
                    w_job.cmds[0] = '{CMD_MOVETO, w_target_s};
                    w_idx  = 3'd1;
                    n_mode = (w_target_s < r_pos) ? ST_UP : ST_DOWN;
                end
            end
            ACT_STOP: begin
                w_job.cmds[0] = '{CMD_STOP, 21'd0};
                w_idx  = 3'd1;
                n_mode = ST_IDLE;
            end
            ACT_HOME: begin
                if (i_cfg.has_limits && i_cfg.bot_fitted) begin
                    w_job.cmds[0] = '{CMD_SPEED, {1'b0, i_cfg.homing_rate}};
                    w_job.cmds[1] = '{CMD_MOVEREL, HOMING_DISTANCE};
                    w_idx   = 3'd2;
                    n_mode  = ST_HOMING;
                    n_phase = PH_TO_BOTTOM;
                end
            end
            default: begin
                // unused action code: status only
            end
        endcase
        w_job.count = w_idx;
        w_job.pos   = w_p;
        w_job.state = n_mode;
    end

    assign o_q_push = (r_state == F_EXEC) && !i_q_full;
    assign o_q_job  = w_job;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_mode  <= ST_UNKNOWN;
            r_phase <= PH_NONE;
        end else begin
            r_state <= n_state;
            if (o_q_push) begin
                r_mode  <= n_mode;
                r_phase <= n_phase;
            end
        end
    end

    // Capture request, then scale percent to steps in two steps
    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_valid) begin
            r_action  <= t_action'(i_user);
            r_pct_req <= i_data[7:0];
            r_running <= i_data[8];
            r_pos     <= i_data[29:9];
            r_top_hit <= i_data[30];
            r_bot_hit <= i_data[31];
            r_stored  <= i_data[52:32];
        end
        if (r_state == F_PROD) begin
            r_prod <= 27'(w_pct_clamped * i_cfg.max_travel);
        end
        if (r_state == F_RECIP) begin
            r_target <= w_recip_full[RECIP_SHIFT +: 20];
        end
    end

endmodule

[sv/bmpc_queue.sv]
// ============================================================================
// bmpc_queue
// Two-entry queue of classified requests between front and back.
// ============================================================================
module bmpc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bmpc_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output bmpc_pkg::t_job o_job
);
    import bmpc_pkg::*;

    t_job       r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_entry[r_rd_ptr];

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Hold entries
    always_ff @(posedge i_clk) begin
        if (i_push) r_entry[r_wr_ptr] <= i_job;
    end

endmodule

[sv/bmpc_back.sv]
// ============================================================================
// bmpc_back
// Plays out a queued command run, then computes the travel percent, with a
// bit-serial divider inside the travel range, and sends the closing status item.
// ============================================================================
module bmpc_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [19:0]                    i_max_travel,
    input  logic                           i_q_valid,
    input  bmpc_pkg::t_job                 i_q_job,
    output logic                           o_q_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [bmpc_pkg::OUT_DATA_W-1:0] o_data,
    output logic                           o_last
);
    import bmpc_pkg::*;

    t_back_state r_state, n_state;
    t_job        r_job;
    logic [2:0]  r_idx;
    logic [26:0] r_rem;
    logic [2:0]  r_bit;
    logic [6:0]  r_quot;

    // Output register
    logic         r_out_valid;
    t_cmd         r_out_cmd;
    logic [20:0]  r_out_value;
    t_blind_state r_out_state;
    logic [6:0]   r_out_pct;
    logic         r_out_last;

    logic               w_out_free;
    logic               w_load_cmd;
    logic               w_load_status;
    logic signed [20:0] w_pos_s;
    logic signed [20:0] w_max_s;
    logic [26:0]        w_trial;
    logic               w_fits;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_pos_s    = $signed(r_job.pos);
    assign w_max_s    = $signed({1'b0, i_max_travel});
    assign w_trial    = {7'd0, i_max_travel} << r_bit;
    assign w_fits     = (r_rem >= w_trial);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: if (i_q_valid) n_state = BK_CMD;
            BK_CMD:  if (r_idx == r_job.count) n_state = BK_SCALE;
            BK_SCALE: begin
                if (i_max_travel == 20'd0 || w_pos_s < 21'sd0 || w_pos_s >= w_max_s) begin
                    n_state = BK_STATUS;
                end else begin
                    n_state = BK_DIV;
                end
            end
            BK_DIV:    if (r_bit == 3'd0) n_state = BK_STATUS;
            BK_STATUS: if (w_out_free) n_state = BK_IDLE;
            default:   n_state = BK_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_q_pop       = (r_state == BK_IDLE) && i_q_valid;
        w_load_cmd    = (r_state == BK_CMD) && (r_idx != r_job.count) && w_out_free;
        w_load_status = (r_state == BK_STATUS) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_cmd || w_load_status) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath: command run, scaling, restoring division
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_job;
            r_idx <= 3'd0;
        end
        if (w_load_cmd) begin
            r_out_cmd   <= r_job.cmds[r_idx[1:0]].code;
            r_out_value <= r_job.cmds[r_idx[1:0]].value;
            r_out_state <= ST_UNKNOWN;
            r_out_pct   <= 7'd0;
            r_out_last  <= 1'b0;
            r_idx       <= r_idx + 3'd1;
        end
        if (r_state == BK_SCALE) begin
            r_rem  <= 27'(r_job.pos[19:0] * 7'd100);
            r_bit  <= 3'd6;
            if (i_max_travel != 20'd0 && w_pos_s >= w_max_s) begin
                r_quot <= 7'd100;
            end else begin
                r_quot <= 7'd0;
            end
        end
        if (r_state == BK_DIV) begin
            if (w_fits) begin
                r_rem         <= r_rem - w_trial;
                r_quot[r_bit] <= 1'b1;
            end
            r_bit <= r_bit - 3'd1;
        end
        if (w_load_status) begin
            r_out_cmd   <= CMD_STATUS;
            r_out_value <= 21'd0;
            r_out_state <= r_job.state;
            r_out_pct   <= r_quot;
            r_out_last  <= 1'b1;
        end
    end

    assign o_valid = r_out_valid;
    assign o_last  = r_out_last;
    assign o_data  = {5'd0, r_out_pct, r_out_state, r_out_value, r_out_cmd};

endmodule

[sv/bmpc_checker.sv]
// ============================================================================
// bmpc_checker
// Port-level checks on the result stream of the blind controller.
// ============================================================================
module bmpc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [bmpc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                            o_m_axis_tlast
);
    import bmpc_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // Closing item of a run is always the status item, and only it
    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tlast == (o_m_axis_tdata[3:0] == CMD_STATUS)))
        else $error("tlast does not match status item");

    // Command items carry no state or percent; status carries percent in range
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tlast ? (o_m_axis_tdata[34:28] <= 7'd100)
                            : (o_m_axis_tdata[34:25] == 10'd0)))
        else $error("bad status fields");

    // No result right after reset
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result valid out of reset");

endmodule

bind blind_motor_position_controller_top bmpc_checker u_bmpc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
